// ----- rtl/tsrw_pkg.sv -----
// shared constants, codes and the clause entry type for the 2-sat random-walk engine
// no dependencies
package tsrw_pkg;

    localparam int MAX_CLAUSES = 1024;
    localparam int MAX_VARS    = 128;

    localparam int SLOT_W  = $clog2(MAX_CLAUSES);
    localparam int VAR_W   = $clog2(MAX_VARS);
    localparam int COUNT_W = $clog2(MAX_CLAUSES + 1);

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FLIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STS_SAT     = 2'd2;
    localparam logic [STATUS_W-1:0] STS_READ    = 2'd3;

    // register indexes
    localparam logic [PADDR_W-3:0] REG_CLAUSE_COUNT = '0;

    typedef struct packed {
        logic [VAR_W-1:0]  first_var;
        logic [VAR_W-1:0]  second_var;
        logic [KIND_W-1:0] kind;
    } clause_t;

endpackage

// ----- rtl/two_sat_random_walk_step_top.sv -----
// random-walk 2-sat local search engine: clause memory, assignment memory and scan pipeline
// depends on tsrw_pkg
//
// results: load and clear go straight to the result state, read passes through a wait state
// for the assignment read, step scans clauses until the first violated one or the end
// throughput: one item at a time; a step is bound by one clause read per cycle
// from the single read port of the clause memory
// reset: clause_count 0, assignment reads as all zero (valid bits cleared), clause memory
// holds no defined contents until written; no clearing pass
module two_sat_random_walk_step_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [tsrw_pkg::CMD_W-1:0]      command,
    input  logic [tsrw_pkg::SLOT_W-1:0]     clause_slot,
    input  logic [tsrw_pkg::VAR_W-1:0]      first_var,
    input  logic [tsrw_pkg::VAR_W-1:0]      second_var,
    input  logic [tsrw_pkg::KIND_W-1:0]     forbidden_pattern,
    input  logic                            coin,
    // response channel
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [tsrw_pkg::STATUS_W-1:0]   status,
    output logic [tsrw_pkg::SLOT_W-1:0]     violated_clause,
    output logic [tsrw_pkg::VAR_W-1:0]      flipped_var,
    output logic                            var_value,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsrw_pkg::PADDR_W-1:0]    paddr,
    input  logic [tsrw_pkg::PDATA_W-1:0]    pwdata,
    output logic [tsrw_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import tsrw_pkg::*;

    // controller states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RDWAIT = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]         state_reg, state_next;

    // configuration
    logic [COUNT_W-1:0] clause_count_reg;
    logic [COUNT_W-1:0] scan_limit;
    logic               cfg_write;

    // memories: clause table and assignment bits
    clause_t            clause_mem [MAX_CLAUSES];
    logic               asg_mem    [MAX_VARS];
    logic [MAX_VARS-1:0] asg_valid_reg;

    clause_t            clause_rd_reg;
    logic               asg_a_reg, asg_b_reg;
    logic               asg_a_vld_reg, asg_b_vld_reg;
    logic               val_a, val_b;
    logic [VAR_W-1:0]   asg_raddr_a, asg_raddr_b;

    logic               asg_we;
    logic [VAR_W-1:0]   asg_waddr;
    logic               asg_wdata;

    // scan pipeline: issue counter, stage 1 (clause data), stage 2 (assignment data)
    logic [COUNT_W-1:0] iss_reg, iss_next;
    logic               s1_v_reg, s1_v_next;
    logic               s2_v_reg, s2_v_next;
    logic [SLOT_W-1:0]  s1_idx_reg, s2_idx_reg;
    clause_t            s2_clause_reg;
    logic               coin_reg;

    logic               accept;
    logic               violated, flip, scan_done;

    // pending result and response register
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_clause_reg;
    logic [VAR_W-1:0]    res_var_reg;
    logic                res_value_reg;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   violated_clause_reg;
    logic [VAR_W-1:0]    flipped_var_reg;
    logic                var_value_reg;
    logic                rsp_free, rsp_load;

    // ------------------------------------------------------------------
    // configuration port: one register, index taken from paddr above the byte bits
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clause_count_reg <= '0;
        end
        else if (cfg_write && (paddr[PADDR_W-1:2] == REG_CLAUSE_COUNT))
        begin
            clause_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_CLAUSE_COUNT)
        begin
            prdata = {{(PDATA_W-COUNT_W){1'b0}}, clause_count_reg};
        end
    end

    // counts above the table depth scan the whole table only
    assign scan_limit = (clause_count_reg > COUNT_W'(MAX_CLAUSES)) ?
                        COUNT_W'(MAX_CLAUSES) : clause_count_reg;

    // ------------------------------------------------------------------
    // command transfer: taken only when idle, even while a response waits
    // ------------------------------------------------------------------
    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    // ------------------------------------------------------------------
    // clause memory: write on load, one registered read per cycle at the issue index
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && (command == CMD_LOAD))
        begin
            clause_mem[clause_slot] <= '{first_var, second_var, forbidden_pattern};
        end
        clause_rd_reg <= clause_mem[iss_reg[SLOT_W-1:0]];
    end

    // ------------------------------------------------------------------
    // assignment memory: two registered read ports, one write port
    // a valid bit per entry stands for the all-zero reset and the clear command
    // ------------------------------------------------------------------
    // port a serves the read command while idle and the clause's first variable during a scan
    assign asg_raddr_a = (state_reg == ST_SCAN) ? clause_rd_reg.first_var : first_var;
    assign asg_raddr_b = clause_rd_reg.second_var;

    always_ff @(posedge clk)
    begin
        if (asg_we)
        begin
            asg_mem[asg_waddr] <= asg_wdata;
        end
        asg_a_reg <= asg_mem[asg_raddr_a];
        asg_b_reg <= asg_mem[asg_raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asg_valid_reg <= '0;
            asg_a_vld_reg <= 1'b0;
            asg_b_vld_reg <= 1'b0;
        end
        else
        begin
            asg_a_vld_reg <= asg_valid_reg[asg_raddr_a];
            asg_b_vld_reg <= asg_valid_reg[asg_raddr_b];
            if (accept && (command == CMD_CLEAR))
            begin
                asg_valid_reg <= '0;
            end
            else if (asg_we)
            begin
                asg_valid_reg[asg_waddr] <= 1'b1;
            end
        end
    end

    assign val_a = asg_a_reg && asg_a_vld_reg;
    assign val_b = asg_b_reg && asg_b_vld_reg;

    // ------------------------------------------------------------------
    // scan evaluation at stage 2
    // no assignment write happens while reads are in flight: the only write is the flip,
    // and it ends the scan and flushes the pipeline, so no forwarding is needed
    // ------------------------------------------------------------------
    assign violated = (val_a == s2_clause_reg.kind[1]) && (val_b == s2_clause_reg.kind[0]);
    assign flip     = (state_reg == ST_SCAN) && s2_v_reg && violated;
    assign scan_done = (state_reg == ST_SCAN) && !s1_v_reg && !s2_v_reg &&
                       (iss_reg >= scan_limit);

    assign asg_we    = flip;
    assign asg_waddr = coin_reg ? s2_clause_reg.second_var : s2_clause_reg.first_var;
    // the flipped variable held the forbidden value, so its new value is the inverse
    assign asg_wdata = coin_reg ? !val_b : !val_a;

    // ------------------------------------------------------------------
    // controller next state
    // ------------------------------------------------------------------
    assign rsp_free = !rsp_valid_reg || rsp_ready;
    assign rsp_load = (state_reg == ST_RESULT) && rsp_free;

    always_comb
    begin
        state_next = state_reg;
        iss_next   = iss_reg;
        s1_v_next  = (state_reg == ST_SCAN) && !flip && (iss_reg < scan_limit);
        s2_v_next  = (state_reg == ST_SCAN) && !flip && s1_v_reg;

        if (s1_v_next)
        begin
            iss_next = iss_reg + COUNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    iss_next = '0;
                    case (command)
                        CMD_STEP: state_next = ST_SCAN;
                        CMD_READ: state_next = ST_RDWAIT;
                        default:  state_next = ST_RESULT;
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_RESULT;
            end
            ST_SCAN:
            begin
                if (flip || scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_valid_next = rsp_load ? 1'b1 : (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_reg       <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline payload and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_idx_reg    <= iss_reg[SLOT_W-1:0];
        s2_idx_reg    <= s1_idx_reg;
        s2_clause_reg <= clause_rd_reg;

        if (accept)
        begin
            coin_reg       <= coin;
            res_status_reg <= STS_DONE;
            res_clause_reg <= '0;
            res_var_reg    <= '0;
            res_value_reg  <= 1'b0;
        end

        if (state_reg == ST_RDWAIT)
        begin
            res_status_reg <= STS_READ;
            res_value_reg  <= val_a;
        end

        if (flip)
        begin
            res_status_reg <= STS_FLIPPED;
            res_clause_reg <= s2_idx_reg;
            res_var_reg    <= asg_waddr;
            res_value_reg  <= asg_wdata;
        end
        else if (scan_done)
        begin
            res_status_reg <= STS_SAT;
        end

        if (rsp_load)
        begin
            status_reg          <= res_status_reg;
            violated_clause_reg <= res_clause_reg;
            flipped_var_reg     <= res_var_reg;
            var_value_reg       <= res_value_reg;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign violated_clause = violated_clause_reg;
    assign flipped_var     = flipped_var_reg;
    assign var_value       = var_value_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the scan pipeline is empty outside a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (!s1_v_reg && !s2_v_reg))
        else $error("scan pipeline busy outside a scan");

    // every transfer leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("command transfer did not start work");

    // a flipped variable is marked written right after the flip
    assert property (@(posedge clk) disable iff (!rst_n)
        asg_we |=> asg_valid_reg[$past(asg_waddr)])
        else $error("flipped variable not marked valid");

    // a response is loaded only from the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid_reg && (state_reg != ST_RESULT)) |=> !rsp_valid_reg)
        else $error("response raised without a result");

endmodule
